// ===== design/psc_pkg.sv =====
// ----------------------------------------------------------------------------
// psc_pkg
// Types and constants shared by the packet sanity classifier modules.
// ----------------------------------------------------------------------------
`default_nettype none

package psc_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_FRAME   = 3'd0,
    REG_SMALL_FRAG  = 3'd1,
    REG_FIRST_FRAG  = 3'd2,
    REG_UDP_SLACK   = 3'd3
  } cfg_reg_e;

  localparam logic [15:0] MIN_FRAME_RST  = 16'd40;
  localparam logic [15:0] SMALL_FRAG_RST = 16'd400;
  localparam logic [15:0] FIRST_FRAG_RST = 16'd1500;
  localparam logic [15:0] UDP_SLACK_RST  = 16'd4;

  typedef enum logic [3:0] {
    V_OK        = 4'd0,
    V_TOO_SHORT = 4'd1,
    V_BAD_IPLEN = 4'd2,
    V_ZERO_TTL  = 4'd3,
    V_BAD_SRC   = 4'd4,
    V_BAD_DST   = 4'd5,
    V_LAND      = 4'd6,
    V_FRAG      = 4'd7,
    V_TCP_NULL  = 4'd8,
    V_XMAS      = 4'd9,
    V_TCP_FLAGS = 4'd10,
    V_TCP_SHORT = 4'd11,
    V_UDP_SHORT = 4'd12
  } verdict_e;

  typedef struct packed {
    logic [15:0] min_frame_bytes;
    logic [15:0] small_fragment_limit;
    logic [15:0] first_fragment_limit;
    logic [15:0] udp_length_slack;
  } cfg_t;

  typedef struct packed {
    logic [15:0] frame_bytes;
    logic [15:0] ip_total_len;
    logic [7:0]  hop_limit;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] frag_word;
    logic [7:0]  proto_num;
    logic [7:0]  tcp_flag_bits;
    logic [15:0] udp_len;
  } in_item_t;

  typedef struct packed {
    logic [3:0] verdict;
    logic       accept;
  } out_item_t;

endpackage

`default_nettype wire

// ===== design/packet_sanity_classifier_core.sv =====
// ----------------------------------------------------------------------------
// packet_sanity_classifier_core
// One verdict per packet header: input register, check logic, result register.
// ----------------------------------------------------------------------------
//  channel  | signals                                 | direction
//  ---------+-----------------------------------------+----------
//  in       | in_valid_i, in_ready_o, in_item_i       | sink
//  out      | out_valid_o, out_ready_i, out_item_o    | source
//  cfg      | cfg_we_i, cfg_idx_i, cfg_data_i         | sink
//
//  Input register, then result register; one item per cycle while the output is not stalled.
//  The check logic between the two registers is the only work stage.
//  A stalled result holds; the input register still takes an item if empty.
//  Reset clears the valid flags and loads the threshold defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_sanity_classifier_core import psc_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire in_item_t              in_item_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output out_item_t                  out_item_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t      cfg;
  in_item_t  item_q;
  logic      item_vld_q, item_vld_d;
  out_item_t res;
  out_item_t res_q;
  logic      res_vld_q, res_vld_d;
  logic      res_free;
  logic      advance;

  psc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  psc_classify u_cls (
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign res_free   = !res_vld_q || out_ready_i;
  assign advance    = item_vld_q && res_free;
  assign in_ready_o = !item_vld_q || res_free;

  always_comb begin
    item_vld_d = item_vld_q;
    if (in_ready_o) begin
      item_vld_d = in_valid_i;
    end
    res_vld_d = res_vld_q;
    if (res_free) begin
      res_vld_d = item_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      item_vld_q <= item_vld_d;
      res_vld_q  <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o = res_vld_q;
  assign out_item_o  = res_q;

endmodule

`default_nettype wire

// ===== design/psc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// psc_cfg_regs
// Threshold registers written through the plain configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

module psc_cfg_regs import psc_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                       cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MIN_FRAME:  cfg_d.min_frame_bytes      = cfg_data_i;
        REG_SMALL_FRAG: cfg_d.small_fragment_limit = cfg_data_i;
        REG_FIRST_FRAG: cfg_d.first_fragment_limit = cfg_data_i;
        REG_UDP_SLACK:  cfg_d.udp_length_slack     = cfg_data_i;
        default:        cfg_d = cfg_q;  // unmapped index: dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_frame_bytes      <= MIN_FRAME_RST;
      cfg_q.small_fragment_limit <= SMALL_FRAG_RST;
      cfg_q.first_fragment_limit <= FIRST_FRAG_RST;
      cfg_q.udp_length_slack     <= UDP_SLACK_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== design/psc_classify.sv =====
// ----------------------------------------------------------------------------
// psc_classify
// Priority-ordered header checks; first failing check sets the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module psc_classify import psc_pkg::*; (
  input  wire in_item_t item_i,
  input  wire cfg_t     cfg_i,
  output out_item_t     res_o
);

  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [7:0]  PROTO_UDP = 8'd17;
  localparam logic [7:0]  F_FIN = 8'h01;
  localparam logic [7:0]  F_SYN = 8'h02;
  localparam logic [7:0]  F_RST = 8'h04;
  localparam logic [7:0]  F_PSH = 8'h08;
  localparam logic [7:0]  F_ACK = 8'h10;
  localparam logic [7:0]  F_URG = 8'h20;
  localparam logic [15:0] IP_HDR_LEN   = 16'd20;
  localparam logic [15:0] TCP_MIN_LEN  = 16'd40;
  localparam logic [15:0] UDP_MIN_LEN  = 16'd28;

  function automatic logic src_bogon(input logic [31:0] a);
    logic hit;
    hit = (a == 32'h0000_0000) || (a == 32'hFFFF_FFFF)
       || ((a & 32'hFF00_0000) == 32'h7F00_0000)
       || ((a & 32'hF000_0000) == 32'hE000_0000)
       || ((a & 32'hF000_0000) == 32'hF000_0000)
       || ((a & 32'hFFFF_0000) == 32'hA9FE_0000)
       || ((a & 32'hFF00_0000) == 32'h0000_0000);
    return hit;
  endfunction

  function automatic verdict_e flag_verdict(input logic [7:0] f);
    verdict_e v;
    if (f == 8'h00) begin
      v = V_TCP_NULL;
    end else if ((f & (F_FIN | F_PSH | F_URG)) == (F_FIN | F_PSH | F_URG)) begin
      v = V_XMAS;
    end else if ((f & (F_SYN | F_FIN)) == (F_SYN | F_FIN)) begin
      v = V_TCP_FLAGS;
    end else if ((f & (F_SYN | F_RST)) == (F_SYN | F_RST)) begin
      v = V_TCP_FLAGS;
    end else if (((f & F_FIN) != 8'h00) && ((f & F_ACK) == 8'h00) && (f != F_FIN)) begin
      v = V_TCP_FLAGS;
    end else begin
      v = V_OK;
    end
    return v;
  endfunction

  logic [12:0] frag_offset;
  logic        more_frags;
  logic [15:0] udp_expect;
  logic [15:0] udp_diff;
  verdict_e    tcp_v;
  verdict_e    verdict;

  assign frag_offset = item_i.frag_word[12:0];
  assign more_frags  = item_i.frag_word[13];
  assign tcp_v       = flag_verdict(item_i.tcp_flag_bits);
  // only consulted once ip_total_len >= 20 has passed, so no wrap
  assign udp_expect = item_i.ip_total_len - IP_HDR_LEN;
  assign udp_diff   = (item_i.udp_len > udp_expect) ? item_i.udp_len - udp_expect
                                                    : udp_expect - item_i.udp_len;

  always_comb begin
    verdict = V_OK;
    if (item_i.frame_bytes < cfg_i.min_frame_bytes) begin
      verdict = V_TOO_SHORT;
    end else if ((item_i.ip_total_len < IP_HDR_LEN) ||
                 (item_i.ip_total_len > item_i.frame_bytes)) begin
      verdict = V_BAD_IPLEN;
    end else if (item_i.hop_limit == 8'd0) begin
      verdict = V_ZERO_TTL;
    end else if (src_bogon(item_i.src_ip)) begin
      verdict = V_BAD_SRC;
    end else if (item_i.dst_ip == 32'd0) begin
      verdict = V_BAD_DST;
    end else if (item_i.src_ip == item_i.dst_ip) begin
      verdict = V_LAND;
    end else if ((frag_offset != 13'd0) &&
                 (item_i.ip_total_len < cfg_i.small_fragment_limit)) begin
      verdict = V_FRAG;
    end else if ((frag_offset == 13'd0) && more_frags &&
                 (item_i.ip_total_len > cfg_i.first_fragment_limit)) begin
      verdict = V_FRAG;
    end else if (item_i.proto_num == PROTO_TCP) begin
      if (tcp_v != V_OK) begin
        verdict = tcp_v;
      end else if (item_i.ip_total_len < TCP_MIN_LEN) begin
        verdict = V_TCP_SHORT;
      end
    end else if (item_i.proto_num == PROTO_UDP) begin
      if ((item_i.udp_len != 16'd0) && (udp_diff > cfg_i.udp_length_slack)) begin
        verdict = V_BAD_IPLEN;
      end else if (item_i.ip_total_len < UDP_MIN_LEN) begin
        verdict = V_UDP_SHORT;
      end
    end
  end

  assign res_o.verdict = verdict;
  assign res_o.accept  = (verdict == V_OK);

endmodule

`default_nettype wire

// ===== design/psc_checker.sv =====
// ----------------------------------------------------------------------------
// psc_checker
// Port-level checks on the classifier, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module psc_checker import psc_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_ready_o,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_item_t out_item_o
);

  // accept flag must agree with the verdict code
  a_accept_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.accept == (out_item_o.verdict == V_OK)))
    else $error("accept does not match verdict");

  // verdict code never beyond the last defined one
  a_verdict_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.verdict <= V_UDP_SHORT))
    else $error("verdict out of range");

  // nothing offered while in reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result offered during reset");

  // stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("stalled result changed");

  // with no result waiting the input side is open
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty result register");

endmodule

bind packet_sanity_classifier_core psc_checker u_psc_checker (.*);

`default_nettype wire

// ===== bench/psc_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// psc_tb_pkg
// Header field codes shared by the classifier testbench and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package psc_tb_pkg;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic [7:0] TCP_FIN = 8'h01;
  localparam logic [7:0] TCP_SYN = 8'h02;
  localparam logic [7:0] TCP_RST = 8'h04;
  localparam logic [7:0] TCP_PSH = 8'h08;
  localparam logic [7:0] TCP_ACK = 8'h10;
  localparam logic [7:0] TCP_URG = 8'h20;

  localparam logic [15:0] FRAG_MORE        = 16'h2000;
  localparam logic [15:0] FRAG_DONT        = 16'h4000;
  localparam logic [15:0] FRAG_OFFSET_MASK = 16'h1FFF;

  localparam logic [15:0] IPV4_HDR_BYTES = 16'd20;
  localparam logic [15:0] TCP_MIN_LEN    = 16'd40;
  localparam logic [15:0] UDP_MIN_LEN    = 16'd28;

endpackage

`default_nettype wire

// ===== bench/psc_checker.sv =====
// ----------------------------------------------------------------------------
// psc_tb_checker
// Watches the classifier's channels and config port, predicts one verdict
// per accepted packet and compares it with each accepted result, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module psc_tb_checker import psc_pkg::*; import psc_tb_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic                  in_ready_i,
  input  wire in_item_t              in_item_i,
  input  wire logic                  out_valid_i,
  input  wire logic                  out_ready_i,
  input  wire out_item_t             out_item_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned                fail_count_o,
  output int unsigned                pending_o
);

  cfg_t        shadow_cfg;
  verdict_e    verdict_queue[$];
  verdict_e    want_verdict;
  int unsigned mismatches = 0;

  function automatic verdict_e judge_packet(in_item_t p, cfg_t c);
    logic [15:0] offset;
    logic        more;
    logic        bogon;
    logic [7:0]  f;
    logic [15:0] udp_want;
    logic [15:0] udp_diff;
    offset = p.frag_word & FRAG_OFFSET_MASK;
    more   = (p.frag_word & FRAG_MORE) != '0;
    bogon  = (p.src_ip == 32'h0) || (p.src_ip == 32'hFFFFFFFF)
          || ((p.src_ip & 32'hFF000000) == 32'h7F000000)
          || ((p.src_ip & 32'hF0000000) == 32'hE0000000)
          || ((p.src_ip & 32'hF0000000) == 32'hF0000000)
          || ((p.src_ip & 32'hFFFF0000) == 32'hA9FE0000)
          || ((p.src_ip & 32'hFF000000) == 32'h0);
    f = p.tcp_flag_bits;

    if (p.frame_bytes < c.min_frame_bytes) return V_TOO_SHORT;
    if (p.ip_total_len < IPV4_HDR_BYTES || p.ip_total_len > p.frame_bytes) return V_BAD_IPLEN;
    if (p.hop_limit == '0) return V_ZERO_TTL;
    if (bogon) return V_BAD_SRC;
    if (p.dst_ip == '0) return V_BAD_DST;
    if (p.src_ip == p.dst_ip) return V_LAND;
    if (offset != '0 && p.ip_total_len < c.small_fragment_limit) return V_FRAG;
    if (offset == '0 && more && p.ip_total_len > c.first_fragment_limit) return V_FRAG;

    if (p.proto_num == PROTO_TCP) begin
      if (f == '0) return V_TCP_NULL;
      if ((f & (TCP_FIN | TCP_PSH | TCP_URG)) == (TCP_FIN | TCP_PSH | TCP_URG)) return V_XMAS;
      if ((f & (TCP_SYN | TCP_FIN)) == (TCP_SYN | TCP_FIN)) return V_TCP_FLAGS;
      if ((f & (TCP_SYN | TCP_RST)) == (TCP_SYN | TCP_RST)) return V_TCP_FLAGS;
      // FIN without ACK is only legal on its own
      if ((f & TCP_FIN) != '0 && (f & TCP_ACK) == '0 && f != TCP_FIN) return V_TCP_FLAGS;
      if (p.ip_total_len < TCP_MIN_LEN) return V_TCP_SHORT;
    end
    if (p.proto_num == PROTO_UDP) begin
      // ip length is at least the header here, so no wrap
      if (p.udp_len != '0) begin
        udp_want = p.ip_total_len - IPV4_HDR_BYTES;
        udp_diff = (p.udp_len > udp_want) ? p.udp_len - udp_want
                                          : udp_want - p.udp_len;
        if (udp_diff > c.udp_length_slack) return V_BAD_IPLEN;
      end
      if (p.ip_total_len < UDP_MIN_LEN) return V_UDP_SHORT;
    end
    return V_OK;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t checker: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      shadow_cfg <= '{MIN_FRAME_RST, SMALL_FRAG_RST, FIRST_FRAG_RST, UDP_SLACK_RST};
      verdict_queue.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MIN_FRAME:  shadow_cfg.min_frame_bytes      <= cfg_data_i;
          REG_SMALL_FRAG: shadow_cfg.small_fragment_limit <= cfg_data_i;
          REG_FIRST_FRAG: shadow_cfg.first_fragment_limit <= cfg_data_i;
          REG_UDP_SLACK:  shadow_cfg.udp_length_slack     <= cfg_data_i;
          default: ;
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        if (verdict_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected result, verdict %0d accept %0b",
                                    out_item_i.verdict, out_item_i.accept));
        end else begin
          want_verdict = verdict_queue.pop_front();
          if (out_item_i.verdict !== want_verdict)
            report_mismatch($sformatf("verdict got %0d want %0d (%s)", out_item_i.verdict,
                                      want_verdict, want_verdict.name()));
          if (out_item_i.accept !== (want_verdict == V_OK))
            report_mismatch($sformatf("accept got %0b for verdict %s",
                                      out_item_i.accept, want_verdict.name()));
        end
      end

      if (in_valid_i && in_ready_i)
        verdict_queue.push_back(judge_packet(in_item_i, shadow_cfg));

      pending_o    <= verdict_queue.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

`default_nettype wire

// ===== bench/packet_sanity_classifier_core_tb.sv =====
// ----------------------------------------------------------------------------
// packet_sanity_classifier_core_tb
// Drives directed and random packet headers through the classifier under
// several threshold settings, with random gaps and output stalls; the
// checker instance predicts and compares every verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_sanity_classifier_core_tb import psc_pkg::*; import psc_tb_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_ITEMS = 150;
  localparam int unsigned ITEM_W      = $bits(in_item_t);

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_item_t              in_item_i;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b1;
  out_item_t             out_item_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  int unsigned stall_draw;
  int unsigned results_taken = 0;
  logic        rx_quiet = 1'b0;
  logic        tx_quiet = 1'b0;
  int unsigned packets_sent = 0;

  packet_sanity_classifier_core DUT (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .in_item_i,
    .out_valid_o, .out_ready_i, .out_item_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  psc_tb_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .in_item_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_item_i(out_item_o),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: random stall after a taken result, with quiet stretches
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!out_ready_i) begin
        if (stall_left <= 1) out_ready_i <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (out_valid_o) begin
        results_taken <= results_taken + 1;
        if (results_taken % 64 == 63) rx_quiet <= ($urandom_range(0, 2) == 0);
        stall_draw = rx_quiet ? 0 : $urandom_range(0, 5);
        if (stall_draw != 0) begin
          out_ready_i <= 1'b0;
          stall_left  <= stall_draw;
        end
      end
    end
  end

  // caller is at a clock edge; returns at the edge the packet is taken
  task automatic send_packet(input in_item_t p);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= p;
    do @(posedge clk_i); while (!in_ready_o);
    packets_sent++;
    if (packets_sent % 64 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // write enable is left high; program_regs lowers it after the batch
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
  endtask

  task automatic program_regs(input cfg_t c);
    set_reg(REG_MIN_FRAME, c.min_frame_bytes);
    set_reg(REG_SMALL_FRAG, c.small_fragment_limit);
    set_reg(REG_FIRST_FRAG, c.first_fragment_limit);
    set_reg(REG_UDP_SLACK, c.udp_length_slack);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic in_item_t clean_tcp();
    in_item_t p;
    p.frame_bytes   = 16'd60;
    p.ip_total_len  = 16'd60;
    p.hop_limit     = 8'd64;
    p.src_ip        = 32'h0A000001;
    p.dst_ip        = 32'h0A000002;
    p.frag_word     = FRAG_DONT;
    p.proto_num     = PROTO_TCP;
    p.tcp_flag_bits = TCP_SYN;
    p.udp_len       = 16'd0;
    return p;
  endfunction

  // mostly plausible headers so the later checks get exercised
  function automatic in_item_t random_packet();
    in_item_t    p;
    int unsigned pick;
    p = in_item_t'(ITEM_W'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    if ($urandom_range(0, 9) == 0) return p;

    p.frame_bytes = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(40, 1600));
    pick = $urandom_range(0, 15);
    if (pick == 0) p.ip_total_len = 16'($urandom_range(0, 30));
    else if (pick == 1) p.ip_total_len = p.frame_bytes + 16'($urandom_range(1, 8));
    else if (pick < 5) p.ip_total_len = 16'($urandom_range(20, 48));
    else if (p.frame_bytes < IPV4_HDR_BYTES) p.ip_total_len = p.frame_bytes;
    else p.ip_total_len = 16'($urandom_range(IPV4_HDR_BYTES, p.frame_bytes));

    p.hop_limit = ($urandom_range(0, 15) == 0) ? 8'd0 : 8'($urandom_range(1, 255));

    case ($urandom_range(0, 15))
      0: p.src_ip = 32'h0;
      1: p.src_ip = 32'hFFFFFFFF;
      2: p.src_ip = {8'h7F, 24'($urandom)};
      3: p.src_ip = {4'hE, 28'($urandom)};
      4: p.src_ip = {4'hF, 28'($urandom)};
      5: p.src_ip = {16'hA9FE, 16'($urandom)};
      6: p.src_ip = {8'h00, 24'($urandom)};
      default: p.src_ip = {8'($urandom_range(1, 223)), 24'($urandom)};
    endcase

    pick = $urandom_range(0, 19);
    if (pick == 0) p.dst_ip = 32'h0;
    else if (pick == 1) p.dst_ip = p.src_ip;

    pick = $urandom_range(0, 9);
    if (pick < 5) p.frag_word = ($urandom_range(0, 1) != 0) ? FRAG_DONT : 16'h0;
    else if (pick < 7) p.frag_word = FRAG_MORE;
    else if (pick < 9) p.frag_word = {3'($urandom), 13'($urandom_range(1, 8191))};

    pick = $urandom_range(0, 9);
    if (pick < 4) p.proto_num = PROTO_TCP;
    else if (pick < 8) p.proto_num = PROTO_UDP;

    if ($urandom_range(0, 1) != 0) begin
      case ($urandom_range(0, 5))
        0: p.tcp_flag_bits = TCP_SYN;
        1: p.tcp_flag_bits = TCP_SYN | TCP_ACK;
        2: p.tcp_flag_bits = TCP_ACK;
        3: p.tcp_flag_bits = TCP_FIN | TCP_ACK;
        4: p.tcp_flag_bits = TCP_RST;
        default: p.tcp_flag_bits = TCP_PSH | TCP_ACK;
      endcase
    end

    pick = $urandom_range(0, 3);
    if (pick == 0) p.udp_len = 16'd0;
    else if (pick > 1)
      p.udp_len = 16'(int'(p.ip_total_len) - 20 + $urandom_range(0, 12) - 6);
    return p;
  endfunction

  initial begin
    in_item_t    p;
    cfg_t        c;
    logic [31:0] bogon_srcs [7];
    int unsigned count;

    bogon_srcs = '{32'h0, 32'hFFFFFFFF, 32'h7F000001, 32'hE0000001,
                   32'hF0000001, 32'hA9FE0101, 32'h00123456};
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_item_i  <= '0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= '0;
    cfg_data_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset thresholds
    send_packet(clean_tcp());
    p = clean_tcp(); p.frame_bytes = 16'd39; send_packet(p);
    p = clean_tcp(); p.ip_total_len = 16'd19; send_packet(p);
    p = clean_tcp(); p.ip_total_len = 16'd61; send_packet(p);
    p = clean_tcp(); p.hop_limit = 8'd0; send_packet(p);
    foreach (bogon_srcs[i]) begin
      p = clean_tcp(); p.src_ip = bogon_srcs[i]; send_packet(p);
    end
    p = clean_tcp(); p.dst_ip = 32'h0; send_packet(p);
    p = clean_tcp(); p.dst_ip = p.src_ip; send_packet(p);
    p = clean_tcp(); p.frag_word = 16'h0010; p.ip_total_len = 16'd100;
    p.frame_bytes = 16'd100; send_packet(p);
    p = clean_tcp(); p.frag_word = FRAG_MORE; p.ip_total_len = 16'd1600;
    p.frame_bytes = 16'd1600; send_packet(p);
    p = clean_tcp(); p.tcp_flag_bits = 8'h00; send_packet(p);
    p = clean_tcp(); p.tcp_flag_bits = TCP_FIN | TCP_PSH | TCP_URG; send_packet(p);
    p = clean_tcp(); p.tcp_flag_bits = TCP_SYN | TCP_FIN; send_packet(p);
    p = clean_tcp(); p.tcp_flag_bits = TCP_SYN | TCP_RST; send_packet(p);
    p = clean_tcp(); p.tcp_flag_bits = TCP_FIN | TCP_PSH; send_packet(p);
    p = clean_tcp(); p.tcp_flag_bits = TCP_FIN; send_packet(p);
    p = clean_tcp(); p.ip_total_len = 16'd39; send_packet(p);
    p = clean_tcp(); p.proto_num = PROTO_UDP; p.ip_total_len = 16'd100;
    p.frame_bytes = 16'd100; p.udp_len = 16'd84; send_packet(p);
    p.udp_len = 16'd90; send_packet(p);
    p = clean_tcp(); p.proto_num = PROTO_UDP; p.ip_total_len = 16'd27; send_packet(p);
    send_packet('1);
    send_packet('0);
    drain_results();

    // random phases under different thresholds, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      count = PHASE_ITEMS;
      case (ph)
        0: c = '{MIN_FRAME_RST, SMALL_FRAG_RST, FIRST_FRAG_RST, UDP_SLACK_RST};
        1: c = '0;
        2: begin
          c = '1;
          count = 40;
        end
        3: c = '{16'h0, 16'hFFFF, 16'h0, 16'h0};
        default: c = '{16'($urandom_range(0, 200)), 16'($urandom_range(0, 2000)),
                       16'($urandom_range(0, 2000)), 16'($urandom_range(0, 20))};
      endcase
      program_regs(c);
      if (ph == 5) begin
        // writes past the last register must leave the thresholds alone
        for (int k = int'(REG_UDP_SLACK) + 1; k < (1 << CFG_IDX_W); k++)
          set_reg(CFG_IDX_W'(k), 16'($urandom));
        @(posedge clk_i);
        cfg_we_i <= 1'b0;
      end
      @(posedge clk_i);
      repeat (count) send_packet(random_packet());
      drain_results();
    end

    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
